// ----- hdl/lssp_pkg.sv -----
// ----------------------------------------------------------------------------
// lssp_pkg: shared types and constants for the line segment steering block
// Holds field widths, register indexes, controller commands and status.
// ----------------------------------------------------------------------------
`default_nettype none
package lssp_pkg;
    localparam int MAX_SEGMENTS_DEF = 20;
    localparam int CFG_W = 21;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_CENTER_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HALF_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HALF_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HALF_WIDE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd6;

    localparam int DIV_W = 32;
    localparam int DEN_W = 10;

    typedef struct packed {
        logic load_seg;    // latch the input beat
        logic seg_seen;    // count a segment against the frame limit
        logic div_start;   // start divider on segment quotient
        logic seg_accum;   // add crossing to sum
        logic avg_start;   // start divider on average
        logic mul_p;       // center and gain products
        logic mul_sum;     // steer sum and saturation
        logic finish;      // commit frame result
        logic out_take;    // result accepted downstream
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic seg_kept;
        logic seg_count;
        logic frame_last;
        logic found;
    } t_status;
endpackage
`default_nettype wire

// ----- hdl/lssp_divider.sv -----
// ----------------------------------------------------------------------------
// lssp_divider: signed restoring divider, one quotient bit per cycle
// Quotient truncates toward zero; denominator is a nonzero magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
module lssp_divider
    import lssp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [DIV_W-1:0] i_num,
    input  wire logic        [DEN_W:0]   i_den_mag,
    input  wire logic                    i_neg,
    output logic                         o_done,
    output logic signed [DIV_W-1:0]      o_quot
);
    logic [DIV_W-1:0] r_q, n_q;
    logic [DEN_W+1:0] r_rem, n_rem;
    logic [DEN_W:0]   r_den;
    logic             r_neg;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic [DEN_W+1:0] w_trial;
    logic [DIV_W-1:0] w_mag;

    assign w_mag = i_num[DIV_W-1] ? DIV_W'(-i_num) : DIV_W'(i_num);

    always_comb begin
        w_trial = {r_rem[DEN_W:0], r_q[DIV_W-1]};
        n_q = {r_q[DIV_W-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'(DIV_W);
                r_q <= w_mag;
                r_rem <= '0;
                r_den <= i_den_mag;
                r_neg <= i_neg ^ i_num[DIV_W-1];
            end else if (r_busy) begin
                r_q <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

// ----- hdl/lssp_datapath.sv -----
// ----------------------------------------------------------------------------
// lssp_datapath: segment test, crossing sums, PD steering and window update
// Holds the frame accumulators, the configuration registers and the output beat.
// ----------------------------------------------------------------------------
`default_nettype none
module lssp_datapath
    import lssp_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic [9:0]         i_seg_x_start,
    input  wire logic [9:0]         i_seg_y_start,
    input  wire logic [9:0]         i_seg_x_end,
    input  wire logic [9:0]         i_seg_y_end,
    input  wire logic               i_has_segment,
    input  wire logic               i_last_in_frame,
    output logic signed [39:0]      o_steer_value,
    output logic signed [15:0]      o_line_center,
    output logic                    o_lines_found,
    output logic [9:0]              o_window_left,
    output logic [10:0]             o_window_right,
    output logic signed [10:0]      o_window_top,
    output logic [10:0]             o_window_bottom
);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1) + 1;

    logic [10:0] r_img_w;
    logic [9:0]  r_ctr_row;
    logic [8:0]  r_hh, r_hw, r_hww;
    logic signed [20:0] r_gp, r_gd;

    logic signed [31:0] r_sum;
    logic [CNT_W-1:0]   r_kept, r_seen;
    logic signed [15:0] r_prev;
    logic signed [39:0] r_hold;
    logic [9:0]         r_left;

    logic [9:0]  r_x0, r_y0;
    logic signed [10:0] r_dx, r_dy;
    logic        r_has, r_last;

    logic signed [31:0] w_num;
    logic [10:0] w_den;
    logic        w_neg;
    logic        w_div_start;
    logic        w_done;
    logic signed [31:0] w_quot;

    logic [10:0] w_adx, w_ady;
    logic [24:0] w_lhs, w_rhs;
    logic signed [10:0] w_dyy;

    logic signed [16:0] r_center;
    logic signed [41:0] r_prod_p, r_prod_d;
    logic signed [43:0] w_steer;
    logic signed [39:0] r_steer;
    logic signed [36:0] w_cent_full;
    logic signed [16:0] w_cdiff;
    logic signed [15:0] w_cent_sat;
    logic [9:0]  w_half_img;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 11'd320; r_ctr_row <= 10'd120; r_hh <= 9'd20;
            r_hw <= 9'd20; r_hww <= 9'd60; r_gp <= '0; r_gd <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:     r_img_w <= i_cfg_data[10:0];
                REG_ROI_CENTER_ROW:  r_ctr_row <= i_cfg_data[9:0];
                REG_ROI_HALF_HEIGHT: r_hh <= i_cfg_data[8:0];
                REG_ROI_HALF_WIDTH:  r_hw <= i_cfg_data[8:0];
                REG_ROI_HALF_WIDE:   r_hww <= i_cfg_data[8:0];
                REG_GAIN_P:          r_gp <= $signed(i_cfg_data);
                REG_GAIN_D:          r_gd <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_half_img = r_img_w[10:1];
    assign w_adx = r_dx[10] ? 11'(-r_dx) : 11'(r_dx);
    assign w_ady = r_dy[10] ? 11'(-r_dy) : 11'(r_dy);
    assign w_lhs = {w_adx, 12'd0};
    assign w_rhs = 25'(w_ady * 14'd8784);
    assign w_dyy = $signed({2'b00, r_hh}) - $signed({1'b0, r_y0});

    always_comb begin
        if (i_cmd.avg_start) begin
            w_num = r_sum;
            w_den = 11'(r_kept);
            w_neg = 1'b0;
        end else begin
            w_num = 32'(r_dx * w_dyy) <<< 4;
            w_den = w_ady;
            w_neg = r_dy[10];
        end
    end
    assign w_div_start = i_cmd.div_start | i_cmd.avg_start;

    lssp_divider u_div (
        .i_clk, .i_rst_n, .i_start(w_div_start), .i_num(w_num),
        .i_den_mag(w_den), .i_neg(w_neg), .o_done(w_done), .o_quot(w_quot)
    );

    assign o_status.div_done = w_done;
    assign o_status.seg_kept = (r_dy != 0) && (w_lhs < w_rhs);
    assign o_status.seg_count = r_has && (r_seen < CNT_W'(MAX_SEGMENTS));
    assign o_status.frame_last = r_last;
    assign o_status.found = r_kept != 0;

    assign w_cent_full = 37'(w_quot) + 37'($signed({1'b0, r_left}) - $signed({1'b0, w_half_img})) * 16;
    assign w_cent_sat = (w_cent_full > 37'sd32767) ? 16'sd32767 :
                        (w_cent_full < -37'sd32768) ? -16'sd32768 : 16'(w_cent_full);
    assign w_cdiff = r_center - 17'(r_prev);
    assign w_steer = -(44'(r_prod_p) + 44'(r_prod_d));

    // window arithmetic from the updated previous center
    logic signed [15:0] w_pc;
    logic signed [16:0] w_pc8;
    logic signed [12:0] w_c;
    logic signed [14:0] w_r, w_l;
    logic [8:0] w_half;
    assign w_pc = o_status.found ? 16'(r_center) : r_prev;
    assign w_pc8 = 17'(w_pc) + 17'sd8;
    assign w_c = 13'(w_pc8[16] ? -((-w_pc8) >>> 4) : (w_pc8 >>> 4));
    assign w_half = o_status.found ? r_hw : r_hww;
    assign w_r = 15'(w_c) + $signed({6'd0, w_half}) + $signed({5'd0, w_half_img});
    assign w_l = 15'(w_c) - $signed({6'd0, w_half}) + $signed({5'd0, w_half_img});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0; r_kept <= '0; r_seen <= '0; r_prev <= '0;
            r_hold <= '0; r_left <= 10'd140;
        end else begin
            if (i_cmd.load_seg) begin
                r_x0 <= i_seg_x_start; r_y0 <= i_seg_y_start;
                r_dx <= $signed({1'b0, i_seg_x_end}) - $signed({1'b0, i_seg_x_start});
                r_dy <= $signed({1'b0, i_seg_y_end}) - $signed({1'b0, i_seg_y_start});
                r_has <= i_has_segment; r_last <= i_last_in_frame;
            end
            if (i_cmd.seg_seen) r_seen <= r_seen + CNT_W'(1);
            if (i_cmd.seg_accum) begin
                r_sum <= r_sum + w_quot + 32'({r_x0, 4'd0});
                r_kept <= r_kept + CNT_W'(1);
            end
            if (i_cmd.mul_p) begin
                r_center <= 17'(w_cent_sat);
            end
            if (i_cmd.mul_sum) begin
                r_steer <= (w_steer > 44'sh7FFFFFFFFF) ? 40'sh7FFFFFFFFF :
                           (w_steer < -44'sh8000000000) ? -40'sh8000000000 :
                           40'(w_steer);
            end
            if (i_cmd.finish) begin
                o_lines_found <= o_status.found;
                if (o_status.found) begin
                    o_steer_value <= r_steer; o_line_center <= 16'(r_center);
                    r_prev <= 16'(r_center); r_hold <= r_steer;
                end else begin
                    o_steer_value <= r_hold; o_line_center <= r_prev;
                end
                if (w_r >= $signed({4'd0, r_img_w}))
                    o_window_right <= r_img_w - 11'd1 & {11{r_img_w != 0}};
                else if (w_r < 0) o_window_right <= '0;
                else o_window_right <= 11'(w_r);
                if (w_l <= 0) begin
                    o_window_left <= '0; r_left <= '0;
                end else if (w_l > 15'sd1023) begin
                    o_window_left <= 10'd1023; r_left <= 10'd1023;
                end else begin
                    o_window_left <= 10'(w_l); r_left <= 10'(w_l);
                end
                o_window_top <= $signed({1'b0, r_ctr_row}) - $signed({2'b0, r_hh});
                o_window_bottom <= {1'b0, r_ctr_row} + {2'b0, r_hh};
                r_sum <= '0; r_kept <= '0; r_seen <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sum || i_cmd.mul_p) begin
            r_prod_p <= 42'(r_center * r_gp);
            r_prod_d <= 42'(w_cdiff * r_gd);
        end
    end
endmodule
`default_nettype wire

// ----- hdl/lssp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lssp_ctrl: sequencer for one beat, from acceptance to result hand-off
// Steps the datapath through segment test, division and frame close.
// ----------------------------------------------------------------------------
`default_nettype none
module lssp_ctrl
    import lssp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_status i_status,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_TEST = 4'd1, S_DIV = 4'd2, S_ACC = 4'd3,
        S_FRAME = 4'd4, S_AVG = 4'd5, S_CEN = 4'd6, S_MULP = 4'd7, S_MULS = 4'd8,
        S_FIN = 4'd9, S_SAT = 4'd11;
    logic [3:0] r_state, n_state;
    logic r_ov;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && !r_ov) begin
                o_cmd.load_seg = 1'b1; n_state = S_TEST;
            end
            S_TEST: begin
                o_cmd.seg_seen = i_status.seg_count;
                if (i_status.seg_count && i_status.seg_kept) begin
                    o_cmd.div_start = 1'b1; n_state = S_DIV;
                end else begin
                    n_state = S_FRAME;
                end
            end
            S_DIV: if (i_status.div_done) n_state = S_ACC;
            S_ACC: begin o_cmd.seg_accum = 1'b1; n_state = S_FRAME; end
            S_FRAME: if (!i_status.frame_last) n_state = S_IDLE;
                else if (i_status.found) begin
                    o_cmd.avg_start = 1'b1; n_state = S_AVG;
                end else n_state = S_FIN;
            S_AVG: if (i_status.div_done) n_state = S_CEN;
            S_CEN: begin o_cmd.mul_p = 1'b1; n_state = S_MULP; end
            S_MULP: begin o_cmd.mul_sum = 1'b1; n_state = S_MULS; end
            S_MULS: begin o_cmd.mul_sum = 1'b1; n_state = S_SAT; end
            S_SAT: n_state = S_FIN;
            S_FIN: begin o_cmd.finish = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
        o_cmd.out_take = r_ov && !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) r_ov <= 1'b1;
            else if (o_cmd.out_take) r_ov <= 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign o_valid = r_ov;
endmodule
`default_nettype wire

// ----- hdl/line_segment_steering_pd.sv -----
// ----------------------------------------------------------------------------
// line_segment_steering_pd: PD steering from the line segments of a frame
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage: segments of one frame enter as beats on the input channel
// (i_valid/o_stall); the beat with i_last_in_frame set closes the frame
// and produces one result beat on the output channel (o_valid/i_stall).
// Other beats produce no result.
// A segment beat passes only the test and frame states when rejected; when kept
// it also runs the bit-serial divider that forms the row crossing.
// Frame close, when lines were found, runs the divider again to average the
// crossings, then the center step and the two multiply stages for the PD terms;
// with no line kept it goes straight to committing the result.
// One beat is in work at a time; the input stalls until it is done.
// A finished result sits in the output register while the receiver
// stalls, and the input stays stalled until that result is taken.
// Synchronous active-low reset clears the frame sums, the steering history and the
// registers to their defaults; the window restarts at 140..180. Configuration is
// written through i_cfg_we/i_cfg_index/i_cfg_data by the user while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none
module line_segment_steering_pd
    import lssp_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [9:0]         i_seg_x_start,
    input  wire logic [9:0]         i_seg_y_start,
    input  wire logic [9:0]         i_seg_x_end,
    input  wire logic [9:0]         i_seg_y_end,
    input  wire logic               i_has_segment,
    input  wire logic               i_last_in_frame,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [39:0]      o_steer_value,
    output logic signed [15:0]      o_line_center,
    output logic                    o_lines_found,
    output logic [9:0]              o_window_left,
    output logic [10:0]             o_window_right,
    output logic signed [10:0]      o_window_top,
    output logic [10:0]             o_window_bottom
);
    t_cmd    w_cmd;
    t_status w_status;

    lssp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    lssp_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_seg_x_start, .i_seg_y_start, .i_seg_x_end, .i_seg_y_end,
        .i_has_segment, .i_last_in_frame,
        .o_steer_value, .o_line_center, .o_lines_found, .o_window_left,
        .o_window_right, .o_window_top, .o_window_bottom
    );
endmodule
`default_nettype wire
